FILE: hw/rtl/mhi_pkg.sv
package mhi_pkg;

  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

FILE: hw/rtl/mhi_ram.sv
// simple dual-port RAM, one write port, one read port, registered read
module mhi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/max_heap_insert_core.sv
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+------------------------------
// request  | in_insert_value                               | start high, busy low at edge
// result   | out_status, out_final_slot,                   | out_valid high for one cycle,
//          | out_element_count, out_top_value              | receiver cannot hold it off
//
// A full or empty heap finishes in the accepting state; otherwise the value climbs through
//   S_CMP (at most log2(HEAP_DEPTH) swaps), then S_PUT if it reaches the root; result is registered.
// Sift-up rate is set by the heap RAM: one parent read and one write a cycle.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are not cleared.
// A new request may be taken while the previous result is on the outputs.
module max_heap_insert_core #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mhi_pkg::value_t in_insert_value,
  output logic            out_valid,
  output logic            out_status,
  output mhi_pkg::slot_t  out_final_slot,
  output mhi_pkg::count_t out_element_count,
  output mhi_pkg::value_t out_top_value
);

  import mhi_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);      // slot index width
  localparam int CW = $clog2(HEAP_DEPTH + 1);  // count width, holds HEAP_DEPTH

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,   // parent data on RAM output, compare and move
    S_PUT    // value climbed to the root
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;     // hole where the value currently sits
  value_t          val_r, val_nxt;     // value being inserted
  logic [CW-1:0]   count_r, count_nxt;
  value_t          root_r, root_nxt;   // shadow of slot 0

  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r, out_status_nxt;
  slot_t           out_final_slot_r, out_final_slot_nxt;
  count_t          out_element_count_r, out_element_count_nxt;
  value_t          out_top_value_r, out_top_value_nxt;

  // RAM port controls
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;

  logic            accept;
  logic            full;
  logic [AW-1:0]   tail_slot;          // first free slot
  logic [AW-1:0]   tail_m1, tail_par;
  logic [AW-1:0]   idx_m1, idx_par;    // parent of current hole
  logic [AW-1:0]   par_m1, par_par;    // grandparent, read ahead on a swap
  logic            done;
  logic [AW-1:0]   done_slot;
  logic [31:0]     slot_ext, count_ext;

  assign accept    = start && !busy;
  assign full      = (count_r == CW'(HEAP_DEPTH));
  assign tail_slot = count_r[AW-1:0];
  assign tail_m1   = tail_slot - AW'(1);
  assign tail_par  = tail_m1 >> 1;
  assign idx_m1    = idx_r - AW'(1);
  assign idx_par   = idx_m1 >> 1;
  assign par_m1    = idx_par - AW'(1);
  assign par_par   = par_m1 >> 1;

  // output fields are fixed width; slot and count are truncated or zero-filled
  assign slot_ext  = 32'(done_slot);
  assign count_ext = 32'(count_nxt);

  always_comb begin
    state_nxt             = state_r;
    idx_nxt               = idx_r;
    val_nxt               = val_r;
    count_nxt             = count_r;
    root_nxt              = root_r;
    out_valid_nxt         = 1'b0;
    out_status_nxt        = out_status_r;
    out_final_slot_nxt    = out_final_slot_r;
    out_element_count_nxt = out_element_count_r;
    out_top_value_nxt     = out_top_value_r;
    wr_en                 = 1'b0;
    wr_addr               = idx_r;
    wr_data               = val_r;
    rd_en                 = 1'b0;
    rd_addr               = idx_par;
    done                  = 1'b0;
    done_slot             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_insert_value;
          if (full) begin
            // dropped: store untouched
            done           = 1'b1;
            out_status_nxt = STATUS_FULL;
          end else if (count_r == '0) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data        = in_insert_value;
            root_nxt       = in_insert_value;
            count_nxt      = CW'(1);
            done           = 1'b1;
            out_status_nxt = STATUS_OK;
          end else begin
            idx_nxt   = tail_slot;
            rd_en     = 1'b1;
            rd_addr   = tail_par;
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        if (val_r > $signed(rd_data)) begin
          // parent moves down into the hole
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data;
          idx_nxt = idx_par;
          if (idx_par == '0) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = par_par;
          end
        end else begin
          wr_en          = 1'b1;
          wr_addr        = idx_r;
          wr_data        = val_r;
          count_nxt      = count_r + CW'(1);
          done           = 1'b1;
          done_slot      = idx_r;
          out_status_nxt = STATUS_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        wr_data        = val_r;
        root_nxt       = val_r;
        count_nxt      = count_r + CW'(1);
        done           = 1'b1;
        out_status_nxt = STATUS_OK;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      out_valid_nxt         = 1'b1;
      out_final_slot_nxt    = slot_ext[SLOT_W-1:0];
      out_element_count_nxt = count_ext[COUNT_W-1:0];
      out_top_value_nxt     = root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r               <= idx_nxt;
    val_r               <= val_nxt;
    root_r              <= root_nxt;
    out_status_r        <= out_status_nxt;
    out_final_slot_r    <= out_final_slot_nxt;
    out_element_count_r <= out_element_count_nxt;
    out_top_value_r     <= out_top_value_nxt;
  end

  mhi_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_final_slot    = out_final_slot_r;
  assign out_element_count = out_element_count_r;
  assign out_top_value     = out_top_value_r;

  // read-ahead never targets the slot written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("heap RAM read and write to same slot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH))
    else $error("element count above heap depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid_r)
    else $error("accepted request neither in flight nor finished");

  a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_OK |-> count_r == $past(count_r) + CW'(1))
    else $error("insert did not advance the count");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STATUS_FULL |-> out_final_slot_r == '0)
    else $error("dropped request reports nonzero slot");

endmodule

FILE: bench/max_heap_insert_core_test.sv
module max_heap_insert_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mhi_pkg::*;

  localparam int HEAP_DEPTH = 1024;

  // Random stimulus size; the directed list comes on top of this.
  localparam int RANDOM_REQUESTS = 1930;
  // Quiet cycles after the last result, well past the longest sift-up.
  localparam int TAIL_CYCLES = 30;
  // Only the first few mismatches get a line of their own.
  localparam int MAX_PRINTED = 20;

  // One result as the block reports it.
  typedef struct {
    logic   status;
    slot_t  slot;
    count_t count;
    value_t top;
  } heap_result_t;

  // Scoreboard: keeps a shadow copy of the heap, predicts the outcome of
  // every accepted request, and matches results against them in order.
  class heap_scoreboard;
    value_t       slots[HEAP_DEPTH];
    int unsigned  fill;
    heap_result_t pending[$];
    int unsigned  errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Insert into the shadow heap: place at the first free slot, then climb
    // while strictly greater than the parent. A full heap drops the value.
    function void note_request(value_t v);
      heap_result_t want;
      int i;
      int p;
      if (fill == HEAP_DEPTH) begin
        want.status = STATUS_FULL;
        want.slot   = '0;
      end else begin
        i = fill;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!(v > slots[p]))
            break;
          slots[i] = slots[p];
          i = p;
        end
        slots[i]    = v;
        want.status = STATUS_OK;
        want.slot   = slot_t'(i);
        fill++;
      end
      want.count = count_t'(fill);
      want.top   = slots[0];
      pending.push_back(want);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED)
        $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(heap_result_t got);
      heap_result_t want;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %b, want %b", got.status, want.status));
      if (got.slot !== want.slot)
        report($sformatf("final_slot %0d, want %0d", got.slot, want.slot));
      if (got.count !== want.count)
        report($sformatf("element_count %0d, want %0d", got.count, want.count));
      if (got.top !== want.top)
        report($sformatf("top_value %0d, want %0d", got.top, want.top));
    endtask

    task close_out();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  value_t in_insert_value = '0;
  logic   out_valid;
  logic   out_status;
  slot_t  out_final_slot;
  count_t out_element_count;
  value_t out_top_value;

  heap_scoreboard sb;
  int unsigned    taken = 0;   // requests accepted so far
  heap_result_t   seen;
  value_t         ramp;        // rising values force long climbs

  max_heap_insert_core #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_insert_value  (in_insert_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_final_slot   (out_final_slot),
    .out_element_count(out_element_count),
    .out_top_value    (out_top_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: everything is sampled at the rising edge. A request counts as
  // taken when start is high and busy low; each out_valid cycle is one
  // result, which the receiver has no way to hold off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_request(in_insert_value);
        taken++;
      end
      if (out_valid) begin
        seen.status = out_status;
        seen.slot   = out_final_slot;
        seen.count  = out_element_count;
        seen.top    = out_top_value;
        sb.check_result(seen);
      end
    end
  end

  // Called just after a falling edge. Presents one request and returns at
  // the falling edge after it was taken; start stays high so a following
  // call goes out back to back.
  task send_request(value_t v);
    int unsigned before_count;
    before_count = taken;
    start           <= 1'b1;
    in_insert_value <= v;
    do
      @(negedge clk);
    while (taken == before_count);
  endtask

  // Drop start for a number of cycles; the data lines carry junk meanwhile.
  task hold_off(int unsigned cycles);
    if (cycles != 0) begin
      start           <= 1'b0;
      in_insert_value <= value_t'($urandom);
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stop sending until every outstanding request has its result back.
  task drain();
    start <= 1'b0;
    while (sb.pending.size() != 0)
      @(negedge clk);
  endtask

  // Value mix for the random part: full range for bit coverage, a narrow
  // band so equal keys are common, and a rising ramp so new values climb
  // to the top of the tree.
  function value_t pick_value();
    case ($urandom_range(0, 2))
      0: return value_t'($urandom);
      1: return value_t'($signed($urandom_range(0, 16)) - 8);
      default: begin
        ramp = ramp + value_t'($urandom_range(1, 4096));
        return ramp;
      end
    endcase
  endfunction

  // Directed requests: empty heap, an equal key that must not climb,
  // climbs all the way to the root, both extremes, alternating bit patterns
  // and a key equal to the root.
  value_t directed[] = '{
    32'sd0, 32'sd0, -32'sd5, 32'sd3, 32'sd7, 32'sd11, 32'sd7, 32'sd100,
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sd1, 32'sd1,
    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh8000_0000, 32'sd200, 32'sd300,
    32'sd400, 32'sd500
  };

  initial begin
    int unsigned sent;
    int unsigned burst;
    sb   = new();
    ramp = value_t'(-(1 << 30));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[k])
      send_request(directed[k]);

    // Sender waits once with everything drained.
    drain();
    @(negedge clk);

    // Random part: bursts of back-to-back requests with gaps between them.
    // The heap fills partway through, so the later requests exercise the
    // full case and the dropped values.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < RANDOM_REQUESTS) begin
          send_request(pick_value());
          sent++;
        end
      end
      if ($urandom_range(0, 39) == 0)
        drain();
      else if ($urandom_range(0, 4) != 0)
        hold_off($urandom_range(1, 15));
    end

    start <= 1'b0;
    while (sb.pending.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.close_out();

    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mhi_pkg.sv
hw/rtl/mhi_ram.sv
hw/rtl/max_heap_insert_core.sv
bench/max_heap_insert_core_test.sv
